/* hdl/sfd_pkg.sv */
// Package of the stereo feedback delay: types, codes, reset values and widths.
// Depends on nothing; every other file of the block imports it.
package sfd_pkg;

    localparam int LINE_DEPTH_DEF  = 65536;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FRAC_BITS = 24;
    localparam int MUL_W     = 26;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int SMP_W     = 16;

    localparam logic [23:0] TGT_L_RST = 24'd3669926;
    localparam logic [23:0] TGT_R_RST = 24'd4722816;
    localparam logic [24:0] COEF_RST  = 25'd7609;
    localparam logic [16:0] FB_RST    = 17'd32768;
    localparam logic [16:0] MIX_RST   = 17'd32768;

    localparam logic [24:0] COEF_ONE = 25'd16777216;
    localparam logic [16:0] GAIN_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TGT_L = 3'd0,
        CFG_TGT_R = 3'd1,
        CFG_COEF  = 3'd2,
        CFG_FB    = 3'd3,
        CFG_MIX   = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_G1, S_G2, S_G3, S_POS, S_RA, S_RB, S_RW,
        S_INT, S_TAP, S_FB, S_ML, S_MLO, S_MHI, S_WR, S_DONE
    } t_state;

    // Saturates a sum of sample and tap to a 16-bit sample.
    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [MUL_W-1:0] v);
        if (v > MUL_W'(32767)) begin
            return 16'sh7fff;
        end else if (v < -MUL_W'(32768)) begin
            return 16'sh8000;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

/* hdl/sfd_in_if.sv */
// Input channel of the stereo feedback delay: one mono sample per beat.
// Depends on sfd_pkg for the sample width.
interface sfd_in_if import sfd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/sfd_out_if.sv */
// Output channel of the stereo feedback delay: one stereo pair per beat.
// Depends on sfd_pkg for the sample width.
interface sfd_out_if import sfd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SMP_W-1:0]  left_out;
    logic [SMP_W-1:0]  right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

/* hdl/sfd_mul.sv */
// Shared signed multiplier of the stereo feedback delay, product registered.
// Depends on sfd_pkg for the operand width.
module sfd_mul import sfd_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [MUL_W-1:0]   i_a,
    input  logic signed [MUL_W-1:0]   i_b,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* hdl/sfd_line.sv */
// One delay line of the stereo feedback delay: a memory with one write port
// and one registered read port. Depends on sfd_pkg for the default depth and width.
module sfd_line import sfd_pkg::*; #(
    parameter int DEPTH = LINE_DEPTH_DEF,
    parameter int WIDTH = SAMPLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/stereo_feedback_delay.sv */
// Stereo feedback delay: after reset the block clears both delay lines (one entry of each
// line a cycle) before it takes its first sample beat. A new sample is taken only in the
// idle state, so each one is finished and loaded before the next is accepted: one shared
// 26 by 26 bit multiplier under a sequencer handles the glide, interpolation, feedback and
// mix products of the left and then the right channel, six products a channel.
// A finished pair waits in an output register, so the next sample is taken meanwhile.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if, sfd_mul and sfd_line.
module stereo_feedback_delay import sfd_pkg::*; #(
    parameter int LINE_DEPTH  = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfd_in_if.sink                i_in,
    sfd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int DW  = AW + FRAC_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int A1W = SB + 19;
    localparam int ACW = A1W + 18;
    localparam logic [DW:0]    LINE_SPAN = (DW+1)'(LINE_DEPTH) << FRAC_BITS;
    localparam logic [DW-1:0]  TGT_LIM   = DW'(LINE_DEPTH - 1) << 8;
    localparam logic [AW-1:0]  LAST_IDX  = AW'(LINE_DEPTH - 1);
    localparam logic signed [ACW-1:0] SB_HI = ACW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [ACW-1:0] SB_LO = -SB_HI - ACW'(1);

    function automatic logic [DW-1:0] tgt_q24(input logic [23:0] t);
        logic [DW-1:0] v;
        v = DW'(t);
        if (v > TGT_LIM) begin
            v = TGT_LIM;
        end
        return v << 16;
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    // Rounding shifts: halves go away from zero.
    function automatic logic signed [PROD_W-1:0] rnd24(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + (PROD_W'(1) <<< (FRAC_BITS - 1))
              - (v[PROD_W-1] ? PROD_W'(1) : PROD_W'(0));
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ACW-1:0] rnd32(input logic signed [ACW-1:0] v);
        logic signed [ACW-1:0] t;
        t = v + (ACW'(1) <<< 31) - (v[ACW-1] ? ACW'(1) : ACW'(0));
        return t >>> 32;
    endfunction

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [ACW-1:0] v);
        if (v > SB_HI) begin
            return SB_HI[SB-1:0];
        end else if (v < SB_LO) begin
            return SB_LO[SB-1:0];
        end
        return v[SB-1:0];
    endfunction

    t_state r_state, n_state;

    logic [23:0] r_tgt_l, r_tgt_r;
    logic [24:0] r_coef;
    logic [16:0] r_fb, r_mix;

    logic [DW-1:0]            r_cur_l, r_cur_r;
    logic                     r_ch;
    logic signed [SMP_W-1:0]  r_s;
    logic [25:0]              r_gacc;
    logic [AW-1:0]            r_idx;
    logic [23:0]              r_frac;
    logic signed [SB-1:0]     r_a, r_b, r_tap;
    logic signed [A1W-1:0]    r_acc1;
    logic signed [PROD_W-1:0] r_lo;
    logic signed [SMP_W-1:0]  r_yl, r_yr, r_ol, r_or;
    logic                     r_ov;
    logic [AW-1:0]            r_wi, r_clr;

    logic [DW-1:0]            cur_sel, tgt_sel, diff, step;
    logic                     up;
    logic [24:0]              coef_c;
    logic [16:0]              mix_c;
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [SB:0]       db;
    logic [DW:0]              pos;
    logic signed [PROD_W-1:0] isum;
    logic signed [ACW-1:0]    acc;
    logic signed [SB-1:0]     wval, rd_sel, rd_l, rd_r, wdata;
    logic signed [SMP_W-1:0]  y;
    logic                     we_l, we_r, load;
    logic [AW-1:0]            waddr, raddr;

    assign cur_sel = r_ch ? r_cur_r : r_cur_l;
    assign tgt_sel = tgt_q24(r_ch ? r_tgt_r : r_tgt_l);
    assign up      = tgt_sel >= cur_sel;
    assign diff    = up ? tgt_sel - cur_sel : cur_sel - tgt_sel;
    assign step    = DW'(prod) + DW'(r_gacc);
    assign coef_c  = (r_coef > COEF_ONE) ? COEF_ONE : r_coef;
    assign mix_c   = (r_mix > GAIN_ONE) ? GAIN_ONE : r_mix;
    assign db      = $signed({r_b[SB-1], r_b}) - $signed({r_a[SB-1], r_a});
    assign isum    = (PROD_W'(r_a) <<< FRAC_BITS) + prod;
    assign acc     = (ACW'(prod) <<< FRAC_BITS) + ACW'(r_lo);
    assign wval    = sat_sb(rnd32(acc));
    assign y       = sat16(MUL_W'(r_s) + MUL_W'(r_tap));
    assign rd_sel  = r_ch ? rd_r : rd_l;
    assign load    = (r_state == S_DONE) && (!r_ov || o_out.ready);

    always_comb begin
        pos = {1'b0, r_wi, {FRAC_BITS{1'b0}}} - {1'b0, cur_sel};
        if (pos[DW]) begin
            pos = pos + LINE_SPAN;
        end
    end

    sfd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_prod (prod)
    );

    sfd_line #(.DEPTH(LINE_DEPTH), .WIDTH(SB)) u_line_l (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_l)
    );

    sfd_line #(.DEPTH(LINE_DEPTH), .WIDTH(SB)) u_line_r (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        op_a    = '0;
        op_b    = '0;
        we_l    = 1'b0;
        we_r    = 1'b0;
        waddr   = r_wi;
        wdata   = wval;
        raddr   = wrap_inc(r_idx);
        case (r_state)
            S_CLR: begin
                we_l  = 1'b1;
                we_r  = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_G1;
                end
            end
            S_G1: begin
                op_a    = MUL_W'(diff[FRAC_BITS-1:0]);
                op_b    = MUL_W'(coef_c);
                n_state = S_G2;
            end
            S_G2: begin
                op_a    = MUL_W'(diff[DW-1:FRAC_BITS]);
                op_b    = MUL_W'(coef_c);
                n_state = S_G3;
            end
            S_G3:  n_state = S_POS;
            S_POS: n_state = S_RA;
            S_RA: begin
                raddr   = r_idx;
                n_state = S_RB;
            end
            S_RB:  n_state = S_RW;
            S_RW:  n_state = S_INT;
            S_INT: begin
                op_a    = MUL_W'(db);
                op_b    = MUL_W'(r_frac);
                n_state = S_TAP;
            end
            S_TAP: n_state = S_FB;
            S_FB: begin
                op_a    = MUL_W'(r_tap);
                op_b    = MUL_W'(r_fb);
                n_state = S_ML;
            end
            S_ML:  n_state = S_MLO;
            S_MLO: begin
                op_a    = MUL_W'(r_acc1[FRAC_BITS-1:0]);
                op_b    = MUL_W'(mix_c);
                n_state = S_MHI;
            end
            S_MHI: begin
                op_a    = MUL_W'(r_acc1 >>> FRAC_BITS);
                op_b    = MUL_W'(mix_c);
                n_state = S_WR;
            end
            S_WR: begin
                we_l    = !r_ch;
                we_r    = r_ch;
                n_state = r_ch ? S_DONE : S_G1;
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);

    // Configuration is taken at any cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_l <= TGT_L_RST;
            r_tgt_r <= TGT_R_RST;
            r_coef  <= COEF_RST;
            r_fb    <= FB_RST;
            r_mix   <= MIX_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TGT_L: r_tgt_l <= i_cfg_data[23:0];
                CFG_TGT_R: r_tgt_r <= i_cfg_data[23:0];
                CFG_COEF:  r_coef  <= i_cfg_data;
                CFG_FB:    r_fb    <= i_cfg_data[16:0];
                CFG_MIX:   r_mix   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_l <= tgt_q24(TGT_L_RST);
            r_cur_r <= tgt_q24(TGT_R_RST);
            r_ch    <= 1'b0;
            r_ov    <= 1'b0;
            r_wi    <= '0;
            r_clr   <= '0;
        end else begin
            if (o_out.valid && o_out.ready && !load) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    r_s  <= $signed(i_in.sample);
                    r_ch <= 1'b0;
                end
                S_G2: r_gacc <= 26'(prod >>> FRAC_BITS);
                S_G3: begin
                    // The step never exceeds the distance while the target holds, so the target is not passed.
                    if (r_ch) begin
                        r_cur_r <= up ? r_cur_r + step : r_cur_r - step;
                    end else begin
                        r_cur_l <= up ? r_cur_l + step : r_cur_l - step;
                    end
                end
                S_POS: begin
                    r_idx  <= pos[DW-1:FRAC_BITS];
                    r_frac <= pos[FRAC_BITS-1:0];
                end
                S_RB:  r_a <= rd_sel;
                S_RW:  r_b <= rd_sel;
                S_TAP: r_tap <= SB'(rnd24(isum));
                S_ML:  r_acc1 <= A1W'(prod) + (A1W'(r_s) <<< 16);
                S_MHI: r_lo <= prod;
                S_WR: begin
                    if (r_ch) begin
                        r_yr <= y;
                    end else begin
                        r_yl <= y;
                        r_ch <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_ol <= r_yl;
                        r_or <= r_yr;
                        r_ov <= 1'b1;
                        r_wi <= wrap_inc(r_wi);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.left_out  = r_ol;
    assign o_out.right_out = r_or;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_ov)
        else $error("finished pair not presented");

    a_wi_only_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_wi))
        else $error("write index moved without a result");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RA) |-> (r_idx <= LAST_IDX))
        else $error("tap read beyond the line");

endmodule
